// ===== rtl/smhb_pkg.sv =====
package smhb_pkg;

   localparam int MAX_BINS = 4096;
   localparam int MAX_FRAME = 4096;

   localparam int FREQ_W = 33;
   localparam int STEP_W = 27;
   localparam int CNT_W = 13;
   localparam int IDX_W = 12;
   localparam int SAMPLE_W = 18;
   localparam int LEVEL_W = 17;
   localparam int ACC_W = 56;
   localparam int BINS_W = 13;
   localparam int CSR_DATA_W = 33;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCAN_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCAN_END = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCAN_STEP = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BINS_IN_USE = 2'd3;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'd65536;

   typedef struct packed {
      logic                cmd;
      logic                first_of_frame;
      logic [SAMPLE_W-1:0] sample_value;
      logic [IDX_W-1:0]    sample_index;
      logic [CNT_W-1:0]    sample_count;
      logic [FREQ_W-1:0]   frame_low_hz;
      logic [FREQ_W-1:0]   frame_high_hz;
      logic [FREQ_W-1:0]   tuned_freq;
      logic [IDX_W-1:0]    read_index;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] read_level;
      logic [IDX_W-1:0]   landed_bin;
      logic               landed;
      logic               sweep_done;
   } rsp_type;

endpackage

// ===== rtl/smhb_if.sv =====
interface smhb_req_if;
   import smhb_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface smhb_rsp_if;
   import smhb_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/smhb_scaler.sv =====
module smhb_scaler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [smhb_pkg::ACC_W-1:0]    num,
   input  logic [smhb_pkg::BINS_W-1:0]   mul,
   input  logic [smhb_pkg::ACC_W-1:0]    den,
   output logic                          busy,
   output logic                          done,
   output logic [smhb_pkg::BINS_W-1:0]   quot
);
   import smhb_pkg::*;

   localparam int STEPS = BINS_W;
   localparam int CW = $clog2(STEPS + 1);

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [ACC_W+1:0]   rem_ff, rem_in;
   logic [BINS_W-1:0]  q_ff, q_in, mul_ff, mul_in;
   logic [ACC_W-1:0]   num_ff, num_in, den_ff, den_in;
   logic [ACC_W+1:0]   t0, t1;
   logic [1:0]         qd;

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      q_in = q_ff;
      mul_in = mul_ff;
      num_in = num_ff;
      den_in = den_ff;
      t0 = '0;
      t1 = '0;
      qd = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(STEPS);
         rem_in = '0;
         q_in = '0;
         mul_in = mul;
         num_in = num;
         den_in = den;
      end else if (busy_ff) begin
         t0 = {rem_ff[ACC_W:0], 1'b0} + (mul_ff[BINS_W-1] ? {2'b00, num_ff} : '0);
         if (t0 >= {2'b00, den_ff}) begin
            t1 = t0 - {2'b00, den_ff};
            qd = 2'd1;
         end else begin
            t1 = t0;
         end
         if (t1 >= {2'b00, den_ff}) begin
            t1 = t1 - {2'b00, den_ff};
            qd = qd + 2'd1;
         end
         rem_in = t1;
         q_in = {q_ff[BINS_W-2:0], 1'b0} + BINS_W'(qd);
         mul_in = {mul_ff[BINS_W-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff <= q_in;
      mul_ff <= mul_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== rtl/sweep_max_hold_binner_core.sv =====
// Sweep peak-hold binner.
// req channel: one request per handshake; cmd selects a sample push or a read
// of one bin of the latest finished sweep. rsp channel: exactly one response
// per request, in order. csr port: write enable, index, data; any write
// clears both bin stores and the sweep tracking.
// A read passes through the MATH1, RDWT and RDOUT states to OUT; a push
// dropped by the settings goes from MATH1 to OUT, and one dropped by its frame
// geometry from MATH2 to OUT. A push that lands waits for the bit-serial
// scaler that forms floor(N*bins/D) one multiplier bit per cycle, then does
// the read-modify-write of the working store.
// A push that completes a sweep first copies each bin into the latest store
// and clears it in the working store. One request is in flight at a time; the
// next request can be taken the cycle after the response is accepted.
// Reset, and any csr write, start a clearing pass over both stores; requests
// are not taken during it.
// When the receiver stalls, the response is held in the output register and
// no further request is accepted until it is taken.
module sweep_max_hold_binner_core (
   input  logic                            clock,
   input  logic                            reset,
   smhb_req_if.sink                        req,
   smhb_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [smhb_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [smhb_pkg::CSR_DATA_W-1:0] csr_data
);
   import smhb_pkg::*;

   localparam int AW = $clog2(MAX_BINS);
   localparam int PW = AW + 1;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MATH1 = 4'd2;
   localparam logic [3:0] S_MATH2 = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_RMW   = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_COPY  = 4'd7;
   localparam logic [3:0] S_RDWT  = 4'd8;
   localparam logic [3:0] S_RDOUT = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_COPYW = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [FREQ_W-1:0]  start_ff, end_ff, prev_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [BINS_W-1:0]  bcfg_ff;
   logic               started_ff;
   req_type            r_ff;
   rsp_type            o_ff;
   logic               ovalid_ff;
   logic [PW-1:0]      ptr_ff;
   logic [ACC_W-1:0]   num_ff, den_ff;
   logic               neg_ff;
   logic [ACC_W+1:0]   a_ff, b_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [AW-1:0]      bin_ff;

   logic [LEVEL_W-1:0] work_mem [MAX_BINS];
   logic [LEVEL_W-1:0] late_mem [MAX_BINS];
   logic [LEVEL_W-1:0] work_rd_ff, late_rd_ff;
   logic               work_we, late_we;
   logic [AW-1:0]      work_wa, late_wa, work_ra, late_ra;
   logic [LEVEL_W-1:0] work_wd, late_wd;

   logic [BINS_W-1:0]  bins_eff;
   logic               cfg_ok;
   logic               div_start, div_busy, div_done;
   logic [BINS_W-1:0]  quot;
   logic [AW-1:0]      bin_sel;
   logic signed [SAMPLE_W-1:0] sv;
   logic [LEVEL_W-1:0] clamp;
   logic               wrap;
   logic [FREQ_W:0]    span;
   logic [FREQ_W+1:0]  twice_start, offs;
   logic               offs_neg;
   logic [ACC_W+1:0]   sum_ab, twice_num, frame_num;
   logic               frame_drop;

   assign bins_eff = (bcfg_ff > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bcfg_ff;
   assign cfg_ok = (bins_eff != '0) && (step_ff != '0) && (end_ff > start_ff);
   assign wrap = (prev_ff != '0) && started_ff &&
                 (({1'b0, r_ff.tuned_freq, 1'b0} + 35'(step_ff)) <
                  {1'b0, prev_ff, 1'b0});
   assign sv = signed'(r_ff.sample_value);
   assign clamp = sv[SAMPLE_W-1] ? '0 :
                  ((sv > signed'(SAMPLE_W'(LEVEL_MAX))) ? LEVEL_MAX :
                   LEVEL_W'(r_ff.sample_value));
   assign bin_sel = (quot >= bins_eff) ? AW'(bins_eff - BINS_W'(1)) : AW'(quot);

   assign span = {1'b0, end_ff} - {1'b0, start_ff} + 34'(step_ff);
   assign twice_start = {1'b0, start_ff, 1'b0};
   assign offs_neg = twice_start < 35'(step_ff);
   assign offs = offs_neg ? (35'(step_ff) - twice_start) : (twice_start - 35'(step_ff));
   assign sum_ab = a_ff + b_ff;
   assign twice_num = {1'b0, num_ff, 1'b0};
   assign frame_num = neg_ff ? (sum_ab + twice_num) : (sum_ab - twice_num);
   assign frame_drop = (r_ff.frame_high_hz <= r_ff.frame_low_hz) ||
                       (r_ff.sample_count == '0) ||
                       (r_ff.sample_count > CNT_W'(MAX_FRAME)) ||
                       ({1'b0, r_ff.sample_index} >= r_ff.sample_count) ||
                       (!neg_ff && (sum_ab < twice_num)) ||
                       (frame_num >= {2'b00, den_ff});

   smhb_scaler u_scaler (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .mul   (bins_eff),
      .den   (den_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (work_we) work_mem[work_wa] <= work_wd;
      work_rd_ff <= work_mem[work_ra];
      if (late_we) late_mem[late_wa] <= late_wd;
      late_rd_ff <= late_mem[late_ra];
   end

   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff && !csr_we;
   assign rsp.valid = ovalid_ff;
   assign rsp.data = o_ff;

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      work_we = 1'b0;
      late_we = 1'b0;
      work_wa = ptr_ff[AW-1:0];
      late_wa = ptr_ff[AW-1:0];
      work_wd = '0;
      late_wd = '0;
      work_ra = ptr_ff[AW-1:0];
      late_ra = r_ff.read_index[AW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            work_we = 1'b1;
            late_we = 1'b1;
            if (ptr_ff == PW'(MAX_BINS - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req.valid && req.ready) state_in = S_MATH1;
         S_MATH1: begin
            priority if (r_ff.cmd == CMD_READ) state_in = S_RDWT;
            else if (!cfg_ok) state_in = S_OUT;
            else if (r_ff.first_of_frame && wrap) state_in = S_COPY;
            else state_in = S_MATH2;
         end
         S_MATH2: state_in = frame_drop ? S_OUT : S_DIV;
         S_DIV: begin
            work_ra = bin_sel;
            if (div_done) state_in = S_RMW;
         end
         S_RMW: begin
            work_ra = bin_ff;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            work_wa = bin_ff;
            work_we = level_ff > work_rd_ff;
            work_wd = level_ff;
            state_in = S_OUT;
         end
         S_COPY: state_in = S_COPYW;
         S_COPYW: begin
            late_we = 1'b1;
            late_wd = work_rd_ff;
            late_wa = ptr_ff[AW-1:0] - AW'(1);
            work_we = 1'b1;
            work_wa = ptr_ff[AW-1:0] - AW'(1);
            work_wd = '0;
            state_in = (ptr_ff == PW'(MAX_BINS)) ? S_MATH2 : S_COPY;
         end
         S_RDWT: state_in = S_RDOUT;
         S_RDOUT: state_in = S_OUT;
         S_OUT: if (!ovalid_ff) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
      if (state_ff == S_DIV && !div_busy && !div_done) div_start = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         state_ff <= S_CLEAR;
         ptr_ff <= '0;
         prev_ff <= '0;
         started_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         if (reset) begin
            start_ff <= '0;
            end_ff <= '0;
            step_ff <= '0;
            bcfg_ff <= '0;
         end else begin
            unique case (csr_index)
               CSR_SCAN_START: start_ff <= csr_data;
               CSR_SCAN_END: end_ff <= csr_data;
               CSR_SCAN_STEP: step_ff <= csr_data[STEP_W-1:0];
               CSR_BINS_IN_USE: bcfg_ff <= csr_data[BINS_W-1:0];
               default: ;
            endcase
         end
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: ptr_ff <= ptr_ff + PW'(1);
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  r_ff <= req.data;
                  o_ff <= '0;
               end
            end
            S_MATH1: begin
               if (r_ff.cmd == CMD_PUSH && cfg_ok) begin
                  started_ff <= 1'b1;
                  if (r_ff.first_of_frame) begin
                     prev_ff <= r_ff.tuned_freq;
                     if (wrap) begin
                        o_ff.sweep_done <= 1'b1;
                        ptr_ff <= '0;
                     end
                  end
                  a_ff <= 58'(r_ff.sample_count) * 58'({r_ff.frame_low_hz, 2'b00});
                  b_ff <= 58'({r_ff.sample_index, 1'b1}) *
                          58'({r_ff.frame_high_hz - r_ff.frame_low_hz, 1'b0});
                  den_ff <= ACC_W'(r_ff.sample_count) * ACC_W'({span, 2'b00});
                  num_ff <= ACC_W'(r_ff.sample_count) * ACC_W'(offs);
                  neg_ff <= offs_neg;
               end
            end
            S_MATH2: if (!frame_drop) num_ff <= ACC_W'(frame_num);
            S_DIV: begin
               if (div_done) bin_ff <= bin_sel;
               level_ff <= clamp;
            end
            S_WRITE: begin
               o_ff.landed <= 1'b1;
               o_ff.landed_bin <= IDX_W'(bin_ff);
            end
            S_COPY: ptr_ff <= ptr_ff + PW'(1);
            S_RDOUT: o_ff.read_level <= late_rd_ff;
            S_OUT: if (!ovalid_ff) ovalid_ff <= 1'b1;
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/smhb_checker.sv =====
module smhb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_landed,
   input logic [11:0] rsp_landed_bin,
   input logic [16:0] rsp_read_level
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while rsp pending");
   a_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_landed |-> rsp_landed_bin == 12'd0) else $error("bin");
   a_lvl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_level <= 17'd65536) else $error("level");
endmodule

bind sweep_max_hold_binner_core smhb_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_landed(rsp.data.landed),
   .rsp_landed_bin(rsp.data.landed_bin), .rsp_read_level(rsp.data.read_level));

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import smhb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   smhb_req_if req_ch ();
   smhb_rsp_if rsp_ch ();

   sweep_max_hold_binner_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int n_items = 0;
   int n_errors = 0;

   longint scan_lo_hz, scan_hi_hz, step_hz, bin_cfg;
   logic [LEVEL_W-1:0] working_lvl [4096];
   logic [LEVEL_W-1:0] latest_lvl [4096];
   longint prev_tuned_hz;
   bit sweep_live;

   task automatic clear_bins();
      for (int i = 0; i < 4096; i++) begin
         working_lvl[i] = '0;
         latest_lvl[i] = '0;
      end
      prev_tuned_hz = 0;
      sweep_live = 1'b0;
   endtask

   task automatic predict_rsp(input req_type r, output rsp_type o);
      longint nbins, num, den, bin, cnt, idx, lo, hi, tuned, lvl;
      logic signed [SAMPLE_W-1:0] sv;
      o = '0;
      if (r.cmd == CMD_READ) begin
         o.read_level = latest_lvl[r.read_index];
         return;
      end
      nbins = (bin_cfg > 4096) ? 4096 : bin_cfg;
      if (nbins == 0 || step_hz == 0 || scan_hi_hz <= scan_lo_hz) return;
      tuned = longint'(r.tuned_freq);
      if (r.first_of_frame) begin
         if (prev_tuned_hz > 0 && 2 * tuned + step_hz < 2 * prev_tuned_hz && sweep_live) begin
            for (int i = 0; i < 4096; i++) begin
               latest_lvl[i] = working_lvl[i];
               working_lvl[i] = '0;
            end
            o.sweep_done = 1'b1;
         end
         prev_tuned_hz = tuned;
      end
      sweep_live = 1'b1;
      cnt = longint'(r.sample_count);
      idx = longint'(r.sample_index);
      lo = longint'(r.frame_low_hz);
      hi = longint'(r.frame_high_hz);
      if (hi <= lo || cnt == 0 || cnt > 4096 || idx >= cnt) return;
      num = 4 * cnt * lo + 2 * (2 * idx + 1) * (hi - lo) - 2 * cnt * (2 * scan_lo_hz - step_hz);
      den = 4 * cnt * (scan_hi_hz - scan_lo_hz + step_hz);
      if (num < 0 || num >= den) return;
      bin = (num * nbins) / den;
      if (bin >= nbins) bin = nbins - 1;
      sv = r.sample_value;
      if (sv < 0) lvl = 0;
      else if (sv > 65536) lvl = 65536;
      else lvl = longint'(sv);
      if (lvl > longint'(working_lvl[bin])) working_lvl[bin] = LEVEL_W'(lvl);
      o.landed_bin = IDX_W'(bin);
      o.landed = 1'b1;
   endtask

   // request driver
   int send_gap = 0;
   bit send_burst = 1'b0;
   bit hold_reqs = 1'b0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_rsp(req_ch.data, e);
            expected_rsps.push_back(e);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_reqs) begin
               req_ch.data <= pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               send_gap = send_burst ? 0 : $urandom_range(0, 5);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   int recv_gap = 0;
   bit recv_burst = 1'b0;
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with none expected: %p", rsp_ch.data);
               n_errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_ch.data.read_level !== e.read_level) begin
                  $error("read_level expected %0d actual %0d", e.read_level,
                         rsp_ch.data.read_level);
                  n_errors++;
               end
               if (rsp_ch.data.landed_bin !== e.landed_bin) begin
                  $error("landed_bin expected %0d actual %0d", e.landed_bin,
                         rsp_ch.data.landed_bin);
                  n_errors++;
               end
               if (rsp_ch.data.landed !== e.landed) begin
                  $error("landed expected %0d actual %0d", e.landed, rsp_ch.data.landed);
                  n_errors++;
               end
               if (rsp_ch.data.sweep_done !== e.sweep_done) begin
                  $error("sweep_done expected %0d actual %0d", e.sweep_done,
                         rsp_ch.data.sweep_done);
                  n_errors++;
               end
            end
         end
         if (!rsp_ch.ready || rsp_ch.valid) begin
            if ($urandom_range(0, 99) == 0) recv_burst = !recv_burst;
            if (recv_gap > 0) begin
               recv_gap--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               recv_gap = recv_burst ? 0 : $urandom_range(0, 5);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      case (idx)
         CSR_SCAN_START: scan_lo_hz = value & 64'h1_FFFF_FFFF;
         CSR_SCAN_END: scan_hi_hz = value & 64'h1_FFFF_FFFF;
         CSR_SCAN_STEP: step_hz = value & 64'h7FF_FFFF;
         CSR_BINS_IN_USE: bin_cfg = value & 64'h1FFF;
      endcase
      clear_bins();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_scan(input longint s, input longint e, input longint st,
                           input longint b);
      wait_drained();
      csr_write(CSR_SCAN_START, s);
      csr_write(CSR_SCAN_END, e);
      csr_write(CSR_SCAN_STEP, st);
      csr_write(CSR_BINS_IN_USE, b);
   endtask

   function automatic req_type rand_req();
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   task automatic add_push(input bit first, input logic [SAMPLE_W-1:0] val,
                           input longint idx, input longint cnt, input longint lo,
                           input longint hi, input longint tuned);
      req_type r;
      r = '0;
      r.cmd = CMD_PUSH;
      r.first_of_frame = first;
      r.sample_value = val;
      r.sample_index = IDX_W'(idx);
      r.sample_count = CNT_W'(cnt);
      r.frame_low_hz = FREQ_W'(lo);
      r.frame_high_hz = FREQ_W'(hi);
      r.tuned_freq = FREQ_W'(tuned);
      r.read_index = IDX_W'($urandom);
      pending_reqs.push_back(r);
      n_items++;
   endtask

   task automatic add_read(input longint idx);
      req_type r;
      r = rand_req();
      r.cmd = CMD_READ;
      r.read_index = IDX_W'(idx);
      pending_reqs.push_back(r);
      n_items++;
   endtask

   task automatic add_noise();
      req_type r;
      r = rand_req();
      pending_reqs.push_back(r);
      n_items++;
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_level();
      return ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom) :
                                            SAMPLE_W'($urandom_range(0, 65536));
   endfunction

   task automatic add_sweeps(input int n_sweeps);
      longint frames, tuned, lo, cnt;
      frames = (scan_hi_hz - scan_lo_hz) / step_hz + 1;
      for (int s = 0; s < n_sweeps; s++) begin
         for (longint f = 0; f < frames; f++) begin
            tuned = scan_lo_hz + f * step_hz;
            lo = (tuned >= step_hz / 2) ? tuned - step_hz / 2 : 0;
            cnt = $urandom_range(1, 6);
            for (longint i = 0; i < cnt; i++) begin
               add_push(i == 0, rand_level(), i, cnt, lo, lo + step_hz, tuned);
               if ($urandom_range(0, 9) == 0) add_read($urandom_range(0, 63));
               if ($urandom_range(0, 19) == 0) add_noise();
            end
         end
         repeat (3) add_read($urandom_range(0, int'((bin_cfg > 64) ? 63 : bin_cfg)));
      end
   endtask

   initial begin
      longint st, b, s, fr;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      scan_lo_hz = 0;
      scan_hi_hz = 0;
      step_hz = 0;
      bin_cfg = 0;
      clear_bins();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pushes ignored, reads zero
      add_push(1'b1, 18'd1000, 0, 1, 100, 200, 150);
      add_read(0);
      add_read(4095);

      set_scan(1000000000, 1010000000, 1000000, 16);
      add_push(1'b1, 18'h1FFFF, 0, 4, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'h20000, 1, 4, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'h3FFFF, 2, 4, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd65537, 3, 4, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 4, 4, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 0, 0, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 0, 8191, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 0, 4097, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 4095, 4096, 999500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 0, 1, 1000500000, 1000500000, 1000000000);
      add_push(1'b0, 18'd500, 0, 1, 0, 1000, 1000000000);
      add_push(1'b1, 18'd65536, 0, 1, 1009500000, 1010500000, 1010000000);
      add_push(1'b1, 18'd700, 0, 1, 999500000, 1000500000, 1000000000);
      add_read(0);
      add_read(15);
      add_read(16);

      set_scan(0, 64'd8000000000, 100000000, 4096);
      add_sweeps(1);
      repeat (200) @(posedge clock);
      hold_reqs = 1'b1;
      while (req_ch.valid || expected_rsps.size() > 0) @(posedge clock);
      hold_reqs = 1'b0;
      wait_drained();
      add_sweeps(1);

      set_scan(64'h1_FFFF_FFFF, 64'h1_FFFF_FFFF, 64'h7FF_FFFF, 64'h1FFF);
      add_noise();
      add_push(1'b1, 18'd5, 0, 1, 0, 10, 5);
      set_scan(100, 50, 10, 4);
      add_push(1'b1, 18'd5, 0, 1, 90, 110, 100);
      set_scan(1000, 2000, 0, 4);
      add_push(1'b1, 18'd5, 0, 1, 990, 1010, 1000);
      set_scan(1000, 2000, 100, 0);
      add_push(1'b1, 18'd5, 0, 1, 990, 1010, 1000);
      set_scan(5000, 5300, 100, 1);
      add_sweeps(2);
      set_scan(5000, 5300, 100, 8191);
      add_sweeps(2);

      while (n_items < 1050) begin
         st = $urandom_range(1, 100000000);
         fr = $urandom_range(2, 10);
         s = (longint'($urandom) << 1 | $urandom_range(0, 1)) % (64'd8000000000 - st * fr);
         b = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 64);
         set_scan(s, s + st * (fr - 1), st, b);
         add_sweeps($urandom_range(2, 3));
         repeat ($urandom_range(0, 4)) add_noise();
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #50000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sweep_max_hold_binner_core.f =====
rtl/smhb_pkg.sv
rtl/smhb_if.sv
rtl/smhb_scaler.sv
rtl/sweep_max_hold_binner_core.sv
rtl/smhb_checker.sv
sim/tb_top.sv
